[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fbsc_pkg.sv]
// ----------------------------------------------------------------------------
// FAT boot sector classifier package
// Types, byte offsets, result codes and limits shared by all modules.
// ----------------------------------------------------------------------------
package fbsc_pkg;

  localparam logic [5:0] OFF_BPS_LO   = 6'd11;
  localparam logic [5:0] OFF_BPS_HI   = 6'd12;
  localparam logic [5:0] OFF_SPC      = 6'd13;
  localparam logic [5:0] OFF_RES_LO   = 6'd14;
  localparam logic [5:0] OFF_RES_HI   = 6'd15;
  localparam logic [5:0] OFF_COPIES   = 6'd16;
  localparam logic [5:0] OFF_ROOT_LO  = 6'd17;
  localparam logic [5:0] OFF_ROOT_HI  = 6'd18;
  localparam logic [5:0] OFF_TSS_LO   = 6'd19;
  localparam logic [5:0] OFF_TSS_HI   = 6'd20;
  localparam logic [5:0] OFF_FATS_LO  = 6'd22;
  localparam logic [5:0] OFF_FATS_HI  = 6'd23;
  localparam logic [5:0] OFF_TSL_B0   = 6'd32;
  localparam logic [5:0] OFF_TSL_B1   = 6'd33;
  localparam logic [5:0] OFF_TSL_B2   = 6'd34;
  localparam logic [5:0] OFF_LAST     = 6'd35;

  localparam logic [31:0] FAT12_LIMIT = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT = 32'd65525;
  localparam logic [5:0]  DIV_STEPS   = 6'd32;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ODD_SIZE   = 3'd1;
  localparam logic [2:0] ST_NO_TOTAL   = 3'd2;
  localparam logic [2:0] ST_TWO_TOTALS = 3'd3;
  localparam logic [2:0] ST_ZERO_DIV   = 3'd4;
  localparam logic [2:0] ST_UNDERFLOW  = 3'd5;

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  typedef enum logic [2:0] {
    S_CAPTURE,
    S_ROOT_LOAD,
    S_ROOT_WAIT,
    S_DATA,
    S_CLU_LOAD,
    S_CLU_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic take_in;
    logic root_start;
    logic root_save;
    logic data_calc;
    logic clu_start;
    logic clu_save;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_byte;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/fbsc_if.sv]
// ----------------------------------------------------------------------------
// FAT boot sector classifier channels
// Valid/ready interfaces for the sector byte stream and the result stream.
// ----------------------------------------------------------------------------
interface fbsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sector_byte;
  logic       sector_start;

  modport source (output valid, output sector_byte, output sector_start, input ready);
  modport sink   (input valid, input sector_byte, input sector_start, output ready);
endinterface

interface fbsc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status_code;
  logic [1:0]  fat_kind;
  logic [31:0] cluster_count;
  logic [31:0] data_sectors;
  logic [15:0] root_sectors;

  modport source (output valid, output status_code, output fat_kind, output cluster_count,
                  output data_sectors, output root_sectors, input ready);
  modport sink   (input valid, input status_code, input fat_kind, input cluster_count,
                  input data_sectors, input root_sectors, output ready);
endinterface

[hw/rtl/fbsc_div.sv]
// ----------------------------------------------------------------------------
// FAT boot sector classifier divider
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbsc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] den_r, den_nxt;
  logic [16:0] shifted;
  logic [16:0] diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    if (start) begin
      cnt_nxt = fbsc_pkg::DIV_STEPS;
      rem_nxt = '0;
      quo_nxt = dividend;
      den_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = diff[15:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[15:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

[hw/rtl/fbsc_ctrl.sv]
// ----------------------------------------------------------------------------
// FAT boot sector classifier controller
// Sequences capture, the two divisions, the data-region arithmetic and the result.
// ----------------------------------------------------------------------------
module fbsc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  fbsc_pkg::sts_t  sts,
  output fbsc_pkg::cmd_t  cmd
);

  fbsc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbsc_pkg::S_CAPTURE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      fbsc_pkg::S_CAPTURE: begin
        cmd.take_in = 1'b1;
        if (sts.last_byte) begin
          state_nxt = fbsc_pkg::S_ROOT_LOAD;
        end
      end
      fbsc_pkg::S_ROOT_LOAD: begin
        cmd.root_start = 1'b1;
        state_nxt      = fbsc_pkg::S_ROOT_WAIT;
      end
      fbsc_pkg::S_ROOT_WAIT: begin
        if (!sts.div_busy) begin
          cmd.root_save = 1'b1;
          state_nxt     = fbsc_pkg::S_DATA;
        end
      end
      fbsc_pkg::S_DATA: begin
        cmd.data_calc = 1'b1;
        state_nxt     = fbsc_pkg::S_CLU_LOAD;
      end
      fbsc_pkg::S_CLU_LOAD: begin
        cmd.clu_start = 1'b1;
        state_nxt     = fbsc_pkg::S_CLU_WAIT;
      end
      fbsc_pkg::S_CLU_WAIT: begin
        if (!sts.div_busy) begin
          cmd.clu_save = 1'b1;
          state_nxt    = fbsc_pkg::S_EMIT;
        end
      end
      fbsc_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = fbsc_pkg::S_CAPTURE;
        end
      end
      default: begin
        state_nxt = fbsc_pkg::S_CAPTURE;
      end
    endcase
  end

endmodule

[hw/rtl/fbsc_dp.sv]
// ----------------------------------------------------------------------------
// FAT boot sector classifier datapath
// Field capture, shared divider, data-region arithmetic and result register.
// ----------------------------------------------------------------------------
module fbsc_dp (
  input  logic           clk,
  input  logic           rst_n,
  fbsc_in_if.sink        in_chan,
  fbsc_out_if.source     out_chan,
  input  fbsc_pkg::cmd_t cmd,
  output fbsc_pkg::sts_t sts
);

  logic [5:0]  off_r, off_nxt;
  logic        done_r, done_nxt;
  logic [15:0] bps_r;
  logic [7:0]  spc_r;
  logic [15:0] res_r;
  logic [7:0]  copies_r;
  logic [15:0] entries_r;
  logic [15:0] tss_r;
  logic [15:0] fats_r;
  logic [31:0] tsl_r;

  logic        in_fire;
  logic        active;
  logic [5:0]  cur_off;
  logic        store_en;

  logic [23:0] prod_r;
  logic [15:0] root_r;
  logic [31:0] data_r;
  logic        uflow_r;
  logic [31:0] clu_r;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_busy;
  logic [31:0] div_quo;

  logic [24:0] overhead;
  logic [31:0] total;
  logic        uflow;
  logic [2:0]  status;
  logic [1:0]  kind;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_clu_r;
  logic [31:0] out_data_r;
  logic [15:0] out_root_r;

  assign in_chan.ready = cmd.take_in;
  assign in_fire       = in_chan.valid && cmd.take_in;
  assign active        = in_chan.sector_start || !done_r;
  assign cur_off       = in_chan.sector_start ? 6'd0 : off_r;
  assign store_en      = in_fire && active;

  always_comb begin
    off_nxt  = off_r;
    done_nxt = done_r;
    if (store_en) begin
      if (cur_off >= fbsc_pkg::OFF_LAST) begin
        off_nxt  = '0;
        done_nxt = 1'b1;
      end else begin
        off_nxt  = cur_off + 6'd1;
        done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r     <= '0;
      done_r    <= 1'b1;
      bps_r     <= '0;
      spc_r     <= '0;
      res_r     <= '0;
      copies_r  <= '0;
      entries_r <= '0;
      tss_r     <= '0;
      fats_r    <= '0;
      tsl_r     <= '0;
    end else begin
      off_r  <= off_nxt;
      done_r <= done_nxt;
      if (store_en) begin
        unique case (cur_off)
          fbsc_pkg::OFF_BPS_LO:  bps_r[7:0]     <= in_chan.sector_byte;
          fbsc_pkg::OFF_BPS_HI:  bps_r[15:8]    <= in_chan.sector_byte;
          fbsc_pkg::OFF_SPC:     spc_r          <= in_chan.sector_byte;
          fbsc_pkg::OFF_RES_LO:  res_r[7:0]     <= in_chan.sector_byte;
          fbsc_pkg::OFF_RES_HI:  res_r[15:8]    <= in_chan.sector_byte;
          fbsc_pkg::OFF_COPIES:  copies_r       <= in_chan.sector_byte;
          fbsc_pkg::OFF_ROOT_LO: entries_r[7:0] <= in_chan.sector_byte;
          fbsc_pkg::OFF_ROOT_HI: entries_r[15:8] <= in_chan.sector_byte;
          fbsc_pkg::OFF_TSS_LO:  tss_r[7:0]     <= in_chan.sector_byte;
          fbsc_pkg::OFF_TSS_HI:  tss_r[15:8]    <= in_chan.sector_byte;
          fbsc_pkg::OFF_FATS_LO: fats_r[7:0]    <= in_chan.sector_byte;
          fbsc_pkg::OFF_FATS_HI: fats_r[15:8]   <= in_chan.sector_byte;
          fbsc_pkg::OFF_TSL_B0:  tsl_r[7:0]     <= in_chan.sector_byte;
          fbsc_pkg::OFF_TSL_B1:  tsl_r[15:8]    <= in_chan.sector_byte;
          fbsc_pkg::OFF_TSL_B2:  tsl_r[23:16]   <= in_chan.sector_byte;
          fbsc_pkg::OFF_LAST:    tsl_r[31:24]   <= in_chan.sector_byte;
          default: begin
          end
        endcase
      end
    end
  end

  assign sts.last_byte = store_en && (cur_off >= fbsc_pkg::OFF_LAST);
  assign sts.div_busy  = div_busy;
  assign sts.out_free  = !out_valid_r || out_chan.ready;

  assign div_start    = cmd.root_start || cmd.clu_start;
  assign div_dividend = cmd.root_start
                        ? ({11'd0, entries_r, 5'd0} + {16'd0, bps_r} - 32'd1)
                        : data_r;
  assign div_divisor  = cmd.root_start ? bps_r : {8'd0, spc_r};

  fbsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign overhead = {9'd0, res_r} + {1'b0, prod_r} + {9'd0, root_r};
  assign total    = (tss_r != '0) ? {16'd0, tss_r} : tsl_r;
  assign uflow    = {7'd0, overhead} > total;

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      prod_r <= copies_r * fats_r;
    end
    if (cmd.root_save) begin
      if (bps_r == '0) begin
        root_r <= '0;
      end else if (div_quo[31:16] != '0) begin
        root_r <= 16'hFFFF;
      end else begin
        root_r <= div_quo[15:0];
      end
    end
    if (cmd.data_calc) begin
      uflow_r <= uflow;
      data_r  <= uflow ? 32'd0 : (total - {7'd0, overhead});
    end
    if (cmd.clu_save) begin
      clu_r <= (uflow_r || (spc_r == '0)) ? 32'd0 : div_quo;
    end
  end

  always_comb begin
    priority if (bps_r[0]) begin
      status = fbsc_pkg::ST_ODD_SIZE;
    end else if ((tss_r == '0) && (tsl_r == '0)) begin
      status = fbsc_pkg::ST_NO_TOTAL;
    end else if ((tss_r != '0) && (tsl_r != '0)) begin
      status = fbsc_pkg::ST_TWO_TOTALS;
    end else if ((bps_r == '0) || (spc_r == '0)) begin
      status = fbsc_pkg::ST_ZERO_DIV;
    end else if (uflow_r) begin
      status = fbsc_pkg::ST_UNDERFLOW;
    end else begin
      status = fbsc_pkg::ST_OK;
    end
  end

  always_comb begin
    priority if (clu_r < fbsc_pkg::FAT12_LIMIT) begin
      kind = fbsc_pkg::KIND_FAT12;
    end else if (clu_r < fbsc_pkg::FAT16_LIMIT) begin
      kind = fbsc_pkg::KIND_FAT16;
    end else begin
      kind = fbsc_pkg::KIND_FAT32;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_status_r <= status;
      out_kind_r   <= kind;
      out_clu_r    <= clu_r;
      out_data_r   <= data_r;
      out_root_r   <= root_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status_code   = out_status_r;
  assign out_chan.fat_kind      = out_kind_r;
  assign out_chan.cluster_count = out_clu_r;
  assign out_chan.data_sectors  = out_data_r;
  assign out_chan.root_sectors  = out_root_r;

endmodule

[hw/rtl/fat_boot_sector_classifier.sv]
// Once the request carrying byte 35 is accepted, the root-directory division, data-region
// calculation and cluster division run in turn; the result is loaded once the previous
// result is read, and input ready is low until then. The two divisions share one restoring
// divider, with 32 steps each. Other bytes are taken at one request per cycle.
// Reset is synchronous and active low; it clears the capture state, fields and result valid.
// ----------------------------------------------------------------------------
// FAT boot sector classifier
// Captures the boot sector parameter block and reports FAT type and geometry.
// ----------------------------------------------------------------------------
module fat_boot_sector_classifier (
  input  logic        clk,
  input  logic        rst_n,
  fbsc_in_if.sink     in_chan,
  fbsc_out_if.source  out_chan
);

  fbsc_pkg::cmd_t cmd;
  fbsc_pkg::sts_t sts;

  fbsc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  fbsc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

[hw/rtl/fbsc_checker.sv]
// ----------------------------------------------------------------------------
// FAT boot sector classifier checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status_code,
  input logic [1:0]  fat_kind,
  input logic [31:0] cluster_count,
  input logic [31:0] data_sectors,
  input logic [15:0] root_sectors
);

  logic        stalled;
  logic [84:0] payload;
  logic        is_fat12;
  logic        few_clusters;
  logic        is_underflow;
  logic        zero_counts;

  assign stalled      = out_valid && !out_ready;
  assign payload      = {status_code, fat_kind, cluster_count, data_sectors, root_sectors};
  assign is_fat12     = (fat_kind == fbsc_pkg::KIND_FAT12);
  assign few_clusters = (cluster_count < fbsc_pkg::FAT12_LIMIT);
  assign is_underflow = out_valid && (status_code == fbsc_pkg::ST_UNDERFLOW);
  assign zero_counts  = (data_sectors == '0) && (cluster_count == '0);

  `ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(payload), "Stalled result changed")
  `ASSERT_SAME(a_kind_fat12, out_valid, is_fat12 == few_clusters, "FAT12 kind is wrong")
  `ASSERT_SAME(a_underflow_zero, is_underflow, zero_counts, "Underflow result is not zero")
  `ASSERT_SAME(a_clu_le_data, out_valid, cluster_count <= data_sectors, "Too many clusters")

endmodule

bind fat_boot_sector_classifier fbsc_checker u_fbsc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .status_code   (out_chan.status_code),
  .fat_kind      (out_chan.fat_kind),
  .cluster_count (out_chan.cluster_count),
  .data_sectors  (out_chan.data_sectors),
  .root_sectors  (out_chan.root_sectors)
);
